// ===== sv/mpwa_pkg.sv =====
`timescale 1ns / 1ps
// mpwa_pkg: shared types, codes and constants of the max pooling argmax unit.
// No dependencies; used by every module of the block.
package mpwa_pkg;

  // Default sizes, handed to the top-level parameters.
  localparam int MAX_DIM_DEF    = 64;
  localparam int MAX_WINDOW_DEF = 8;

  // Field widths fixed by the interface.
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int DIM_W      = 7;
  localparam int WIN_W      = 4;
  localparam int POS_W      = 6;
  localparam int SAMPLE_W   = 16;
  localparam int INDEX_W    = 13;
  localparam int LOAD_W     = 12;

  // Window coordinate: row * stride plus window offset stays below 2**11.
  localparam int RC_W      = 11;
  // Row start address r * width, wide enough for any coordinate and width.
  localparam int ROWADDR_W = RC_W + DIM_W;

  // Request selector codes.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_POOL = 1'b1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_STEP = 2'd3;

  // Empty-window result.
  localparam logic signed [SAMPLE_W-1:0] Q_MIN     = 16'sh8000;
  localparam logic signed [INDEX_W-1:0]  IDX_NONE  = '1;

  typedef struct packed {
    logic [DIM_W-1:0] in_height;
    logic [DIM_W-1:0] in_width;
    logic [WIN_W-1:0] pool_size;
    logic [WIN_W-1:0] stride_step;
  } cfg_t;

  // One window position handed from the address walker to the plane read.
  typedef struct packed {
    logic                 vld;   // position inside the plane: read it
    logic                 done;  // last position of the window (or empty window)
    logic [ROWADDR_W-1:0] idx;   // plane index of the position
  } issue_t;

endpackage

// ===== sv/mpwa_walker.sv =====
`timescale 1ns / 1ps
// mpwa_walker: window address sequencer, one window position per cycle.
// Depends on mpwa_pkg (cfg_t, issue_t, widths).
module mpwa_walker #(
  parameter int MAX_DIM    = mpwa_pkg::MAX_DIM_DEF,
  parameter int MAX_WINDOW = mpwa_pkg::MAX_WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mpwa_pkg::POS_W-1:0]    row,
  input  logic [mpwa_pkg::POS_W-1:0]    col,
  input  mpwa_pkg::cfg_t                cfg,
  output mpwa_pkg::issue_t              iss
);

  localparam logic [1:0] WS_IDLE = 2'd0;
  localparam logic [1:0] WS_BASE = 2'd1;
  localparam logic [1:0] WS_ROW  = 2'd2;
  localparam logic [1:0] WS_SCAN = 2'd3;

  logic [1:0]                        st_r, st_nxt;
  logic [mpwa_pkg::POS_W-1:0]        row_r, row_nxt, col_r, col_nxt;
  logic [mpwa_pkg::RC_W-1:0]         r_r, r_nxt, c_r, c_nxt, c0_r, c0_nxt;
  logic [mpwa_pkg::WIN_W-1:0]        n_r, n_nxt, m_r, m_nxt;
  logic [mpwa_pkg::ROWADDR_W-1:0]    rowaddr_r, rowaddr_nxt;
  logic [mpwa_pkg::DIM_W-1:0]        h_sat, w_sat;
  logic [mpwa_pkg::WIN_W-1:0]        size_sat, size_m1;
  logic                              row_end, last;

  // Clamp the plane and window sizes to what the store and counters hold.
  assign h_sat = (32'(cfg.in_height) > MAX_DIM) ? mpwa_pkg::DIM_W'(MAX_DIM) : cfg.in_height;
  assign w_sat = (32'(cfg.in_width) > MAX_DIM) ? mpwa_pkg::DIM_W'(MAX_DIM) : cfg.in_width;
  assign size_sat = (32'(cfg.pool_size) > MAX_WINDOW) ? mpwa_pkg::WIN_W'(MAX_WINDOW)
                                                      : cfg.pool_size;
  assign size_m1 = size_sat - mpwa_pkg::WIN_W'(1);
  assign row_end = (m_r == size_m1);
  assign last    = row_end && (n_r == size_m1);

  assign iss.vld  = (st_r == WS_SCAN) && (r_r < mpwa_pkg::RC_W'(h_sat))
                    && (c_r < mpwa_pkg::RC_W'(w_sat));
  assign iss.done = ((st_r == WS_ROW) && (size_sat == '0)) || ((st_r == WS_SCAN) && last);
  assign iss.idx  = rowaddr_r + mpwa_pkg::ROWADDR_W'(c_r);

  always_comb begin
    st_nxt      = st_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    r_nxt       = r_r;
    c_nxt       = c_r;
    c0_nxt      = c0_r;
    n_nxt       = n_r;
    m_nxt       = m_r;
    rowaddr_nxt = rowaddr_r;
    unique case (st_r)
      WS_IDLE: begin
        if (start) begin
          row_nxt = row;
          col_nxt = col;
          st_nxt  = WS_BASE;
        end
      end
      WS_BASE: begin
        r_nxt  = mpwa_pkg::RC_W'(row_r) * mpwa_pkg::RC_W'(cfg.stride_step);
        c0_nxt = mpwa_pkg::RC_W'(col_r) * mpwa_pkg::RC_W'(cfg.stride_step);
        c_nxt  = mpwa_pkg::RC_W'(col_r) * mpwa_pkg::RC_W'(cfg.stride_step);
        n_nxt  = '0;
        m_nxt  = '0;
        st_nxt = WS_ROW;
      end
      WS_ROW: begin
        rowaddr_nxt = mpwa_pkg::ROWADDR_W'(r_r) * mpwa_pkg::ROWADDR_W'(w_sat);
        st_nxt      = (size_sat == '0) ? WS_IDLE : WS_SCAN;
      end
      WS_SCAN: begin
        // Advance along the row; wrap to the next row by adding one width.
        if (row_end) begin
          m_nxt       = '0;
          c_nxt       = c0_r;
          n_nxt       = n_r + mpwa_pkg::WIN_W'(1);
          r_nxt       = r_r + mpwa_pkg::RC_W'(1);
          rowaddr_nxt = rowaddr_r + mpwa_pkg::ROWADDR_W'(w_sat);
        end else begin
          m_nxt = m_r + mpwa_pkg::WIN_W'(1);
          c_nxt = c_r + mpwa_pkg::RC_W'(1);
        end
        if (last) begin
          st_nxt = WS_IDLE;
        end
      end
      default: st_nxt = WS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= WS_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    r_r       <= r_nxt;
    c_r       <= c_nxt;
    c0_r      <= c0_nxt;
    n_r       <= n_nxt;
    m_r       <= m_nxt;
    rowaddr_r <= rowaddr_nxt;
  end

endmodule

// ===== sv/max_pool_window_argmax_unit.sv =====
`timescale 1ns / 1ps
// max_pool_window_argmax_unit: top level, plane store, shared compare unit, result register.
// Depends on mpwa_pkg and mpwa_walker.
//
//  channel | ports                                                   | direction
//  --------+---------------------------------------------------------+----------
//  in      | in_valid/in_ready, func, load_address, sample_value,    | request in
//          | out_row, out_col                                        |
//  out     | out_valid/out_ready, max_value, max_index               | result out
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data                | register write
//
// A load request writes the store at the accept edge.
// A pool request runs setup in the walker (base multiply, then row address
// multiply), one plane read per window position, then the registered read
// and the last compare.
// in_ready is high only while no pool request is in flight; a finished result
// waits in the output register, and a second pool result stalls only if the
// first is still not taken. Reset (synchronous, rst_n low) clears control
// state and sets the registers to their defaults; the store is not cleared.
module max_pool_window_argmax_unit #(
  parameter int MAX_DIM    = mpwa_pkg::MAX_DIM_DEF,
  parameter int MAX_WINDOW = mpwa_pkg::MAX_WINDOW_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_func,
  input  logic [mpwa_pkg::LOAD_W-1:0]           in_load_address,
  input  logic signed [mpwa_pkg::SAMPLE_W-1:0]  in_sample_value,
  input  logic [mpwa_pkg::POS_W-1:0]            in_out_row,
  input  logic [mpwa_pkg::POS_W-1:0]            in_out_col,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [mpwa_pkg::SAMPLE_W-1:0]  out_max_value,
  output logic signed [mpwa_pkg::INDEX_W-1:0]   out_max_index,
  // register write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mpwa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mpwa_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [1:0] TOP_IDLE = 2'd0;
  localparam logic [1:0] TOP_SCAN = 2'd1;
  localparam logic [1:0] TOP_DONE = 2'd2;

  logic [1:0]                           st_r, st_nxt;
  mpwa_pkg::cfg_t                       cfg_r;
  mpwa_pkg::issue_t                     iss;

  // Plane store, written by loads, read once per window position.
  logic [mpwa_pkg::SAMPLE_W-1:0]        plane [DEPTH];

  // Read stage.
  logic                                 rd_vld_r, rd_done_r;
  logic signed [mpwa_pkg::SAMPLE_W-1:0] rd_q_r;
  logic [ADDR_W-1:0]                    rd_idx_r;

  // Running maximum and result register.
  logic signed [mpwa_pkg::SAMPLE_W-1:0] best_r, best_nxt;
  logic signed [mpwa_pkg::INDEX_W-1:0]  bidx_r, bidx_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic signed [mpwa_pkg::SAMPLE_W-1:0] omv_r, omv_nxt;
  logic signed [mpwa_pkg::INDEX_W-1:0]  omi_r, omi_nxt;

  logic                                 in_acc, pool_acc, load_wr, slot_free, cand_gt;
  logic signed [mpwa_pkg::SAMPLE_W-1:0] win_v;
  logic signed [mpwa_pkg::INDEX_W-1:0]  win_i;

  assign in_ready  = (st_r == TOP_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign pool_acc  = in_acc && (in_func == mpwa_pkg::FUNC_POOL);
  // Drop loads that land beyond the store.
  assign load_wr   = in_acc && (in_func == mpwa_pkg::FUNC_LOAD)
                     && (32'(in_load_address) < DEPTH);
  assign slot_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_max_value = omv_r;
  assign out_max_index = omi_r;

  mpwa_walker #(
    .MAX_DIM    (MAX_DIM),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_walker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pool_acc),
    .row   (in_out_row),
    .col   (in_out_col),
    .cfg   (cfg_r),
    .iss   (iss)
  );

  // Register file; the user writes only while the block is idle, not enforced here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_height   <= mpwa_pkg::DIM_W'(64);
      cfg_r.in_width    <= mpwa_pkg::DIM_W'(64);
      cfg_r.pool_size   <= mpwa_pkg::WIN_W'(2);
      cfg_r.stride_step <= mpwa_pkg::WIN_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mpwa_pkg::REG_IN_HEIGHT:   cfg_r.in_height   <= cfg_data;
        mpwa_pkg::REG_IN_WIDTH:    cfg_r.in_width    <= cfg_data;
        mpwa_pkg::REG_POOL_SIZE:   cfg_r.pool_size   <= cfg_data[mpwa_pkg::WIN_W-1:0];
        mpwa_pkg::REG_STRIDE_STEP: cfg_r.stride_step <= cfg_data[mpwa_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Store write port and registered read port.
  always_ff @(posedge clk) begin
    if (load_wr) begin
      plane[ADDR_W'(in_load_address)] <= in_sample_value;
    end
    rd_q_r   <= plane[ADDR_W'(iss.idx)];
    rd_idx_r <= ADDR_W'(iss.idx);
  end

  // Shared compare: strictly greater replaces, so the first maximum wins.
  assign cand_gt = rd_vld_r && (rd_q_r > best_r);
  assign win_v   = cand_gt ? rd_q_r : best_r;
  assign win_i   = cand_gt ? mpwa_pkg::INDEX_W'(rd_idx_r) : bidx_r;

  always_comb begin
    st_nxt        = st_r;
    best_nxt      = best_r;
    bidx_nxt      = bidx_r;
    out_valid_nxt = out_valid_r;
    omv_nxt       = omv_r;
    omi_nxt       = omi_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (st_r)
      TOP_IDLE: begin
        if (pool_acc) begin
          best_nxt = mpwa_pkg::Q_MIN;
          bidx_nxt = mpwa_pkg::IDX_NONE;
          st_nxt   = TOP_SCAN;
        end
      end
      TOP_SCAN: begin
        best_nxt = win_v;
        bidx_nxt = win_i;
        if (rd_done_r) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            omv_nxt       = win_v;
            omi_nxt       = win_i;
            st_nxt        = TOP_IDLE;
          end else begin
            st_nxt = TOP_DONE;
          end
        end
      end
      TOP_DONE: begin
        // Hold the finished result until the output register frees up.
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          omv_nxt       = best_r;
          omi_nxt       = bidx_r;
          st_nxt        = TOP_IDLE;
        end
      end
      default: st_nxt = TOP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= TOP_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      rd_done_r   <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= iss.vld;
      rd_done_r   <= iss.done;
    end
    best_r <= best_nxt;
    bidx_r <= bidx_nxt;
    omv_r  <= omv_nxt;
    omi_r  <= omi_nxt;
  end

endmodule

// ===== sv/mpwa_checker.sv =====
`timescale 1ns / 1ps
// mpwa_checker: port-level assertions for max_pool_window_argmax_unit, plus its bind.
// Depends on mpwa_pkg and the top-level port list.
module mpwa_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  in_func,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [mpwa_pkg::SAMPLE_W-1:0]  out_max_value,
  input logic signed [mpwa_pkg::INDEX_W-1:0]   out_max_index
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_max_value)
                                && $stable(out_max_index))
    else $error("result changed while stalled");

  // No index means the window held nothing above the minimum.
  a_none_is_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_max_index == mpwa_pkg::IDX_NONE) |-> out_max_value == mpwa_pkg::Q_MIN)
    else $error("empty result carries a value other than the minimum");

  // A real index always comes with a sample strictly above the minimum.
  a_found_above_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_max_index != mpwa_pkg::IDX_NONE) |-> out_max_value != mpwa_pkg::Q_MIN)
    else $error("indexed result at the minimum value");

  // A load request never raises a result.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == mpwa_pkg::FUNC_LOAD) && !out_valid |=> !out_valid)
    else $error("load request produced a result");

  // A pool request keeps the request side closed while it scans.
  a_pool_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == mpwa_pkg::FUNC_POOL) |=> !in_ready)
    else $error("request accepted during a pool scan");

endmodule

bind max_pool_window_argmax_unit mpwa_checker u_mpwa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_func       (in_func),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_max_value (out_max_value),
  .out_max_index (out_max_index)
);

// ===== tb/tb_max_pool_window_argmax_unit.sv =====
`timescale 1ns / 1ps
// tb_max_pool_window_argmax_unit: self-checking bench for the max pooling argmax unit.
// Depends on mpwa_pkg and max_pool_window_argmax_unit; predicts every pooled result
// from its own copy of the plane and the registers and checks it at the result port.
module tb_max_pool_window_argmax_unit;

  localparam int PLANE_DIM   = mpwa_pkg::MAX_DIM_DEF;
  localparam int WINDOW_MAX  = mpwa_pkg::MAX_WINDOW_DEF;
  localparam int PLANE_CELLS = PLANE_DIM * PLANE_DIM;
  // Quiet wait after each phase, longer than the longest pool request (8*8 plane reads).
  localparam int SETTLE_CYCLES  = 80;
  // Long receiver hold-off, so the result register fills and in_ready drops.
  localparam int HOLD_AT        = 40;
  localparam int HOLD_CYCLES    = 400;
  // Cycles with no request, result or register write accepted before giving up.
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic                                 func;
    logic [mpwa_pkg::LOAD_W-1:0]          addr;
    logic signed [mpwa_pkg::SAMPLE_W-1:0] sample;
    logic [mpwa_pkg::POS_W-1:0]           row;
    logic [mpwa_pkg::POS_W-1:0]           col;
  } request_t;

  typedef struct packed {
    logic signed [mpwa_pkg::SAMPLE_W-1:0] value;
    logic signed [mpwa_pkg::INDEX_W-1:0]  index;
  } pool_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                                 in_valid        = 1'b0;
  logic                                 in_ready;
  logic                                 in_func         = mpwa_pkg::FUNC_LOAD;
  logic [mpwa_pkg::LOAD_W-1:0]          in_load_address = '0;
  logic signed [mpwa_pkg::SAMPLE_W-1:0] in_sample_value = '0;
  logic [mpwa_pkg::POS_W-1:0]           in_out_row      = '0;
  logic [mpwa_pkg::POS_W-1:0]           in_out_col      = '0;

  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic signed [mpwa_pkg::SAMPLE_W-1:0] out_max_value;
  logic signed [mpwa_pkg::INDEX_W-1:0]  out_max_index;

  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [mpwa_pkg::CFG_IDX_W-1:0]       cfg_index = mpwa_pkg::REG_IN_HEIGHT;
  logic [mpwa_pkg::CFG_DATA_W-1:0]      cfg_data  = '0;

  // Bench copy of the block state: registers at their reset values, the plane
  // as seen by accepted loads, and which cells the stimulus has already loaded.
  logic [mpwa_pkg::DIM_W-1:0]           plane_rows    = 7'd64;
  logic [mpwa_pkg::DIM_W-1:0]           plane_cols    = 7'd64;
  logic [mpwa_pkg::WIN_W-1:0]           window_side   = 4'd2;
  logic [mpwa_pkg::WIN_W-1:0]           window_stride = 4'd2;
  logic signed [mpwa_pkg::SAMPLE_W-1:0] plane_copy    [PLANE_CELLS];
  bit                                   plane_loaded  [PLANE_CELLS];

  request_t     request_queue   [$];
  pool_result_t expected_maxima [$];

  int requests_taken = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int hold_left      = 0;
  bit held_off       = 1'b0;
  int quiet_cycles   = 0;

  // Each phase: in_height, in_width, pool_size, stride_step, random steps.
  // Covers both extremes, out-of-range sizes, zero window and zero stride.
  int phase_plan [9][5] = '{
    '{64, 64, 8, 8, 6},
    '{1, 1, 1, 1, 40},
    '{7, 5, 3, 2, 150},
    '{0, 10, 2, 2, 30},
    '{100, 127, 2, 1, 60},
    '{9, 9, 0, 1, 30},
    '{12, 10, 15, 3, 100},
    '{8, 6, 3, 0, 60},
    '{16, 16, 4, 4, 250}
  };

  max_pool_window_argmax_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_load_address (in_load_address),
    .in_sample_value (in_sample_value),
    .in_out_row      (in_out_row),
    .in_out_col      (in_out_col),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_max_value   (out_max_value),
    .out_max_index   (out_max_index),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // Effective geometry: sizes above the store or window limit saturate.
  function automatic int sat_rows();
    return (plane_rows > PLANE_DIM) ? PLANE_DIM : int'(plane_rows);
  endfunction

  function automatic int sat_cols();
    return (plane_cols > PLANE_DIM) ? PLANE_DIM : int'(plane_cols);
  endfunction

  function automatic int sat_side();
    return (window_side > WINDOW_MAX) ? WINDOW_MAX : int'(window_side);
  endfunction

  // Scan the window in raster order; only a strictly greater sample takes over,
  // so the first maximum wins and an all-minimum or empty window gives none.
  function automatic pool_result_t window_max(input logic [mpwa_pkg::POS_W-1:0] row,
                                              input logic [mpwa_pkg::POS_W-1:0] col);
    pool_result_t best;
    int           rr;
    int           cc;
    int           idx;
    best.value = mpwa_pkg::Q_MIN;
    best.index = mpwa_pkg::IDX_NONE;
    for (int n = 0; n < sat_side(); n++) begin
      for (int m = 0; m < sat_side(); m++) begin
        rr = int'(row) * int'(window_stride) + n;
        cc = int'(col) * int'(window_stride) + m;
        if (rr < sat_rows() && cc < sat_cols()) begin
          idx = rr * sat_cols() + cc;
          if (plane_copy[idx] > best.value) begin
            best.value = plane_copy[idx];
            best.index = mpwa_pkg::INDEX_W'(idx);
          end
        end
      end
    end
    return best;
  endfunction

  // Mix extremes and a few small values, so ties and all-minimum windows occur.
  function automatic logic signed [mpwa_pkg::SAMPLE_W-1:0] random_sample();
    case ($urandom_range(9))
      0:       return mpwa_pkg::Q_MIN;
      1:       return 16'sh7fff;
      2, 3:    return mpwa_pkg::SAMPLE_W'(($urandom_range(3) - 1) * 256);
      default: return mpwa_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic queue_load(input int addr,
                            input logic signed [mpwa_pkg::SAMPLE_W-1:0] sample);
    request_t req;
    req.func   = mpwa_pkg::FUNC_LOAD;
    req.addr   = mpwa_pkg::LOAD_W'(addr);
    req.sample = sample;
    req.row    = mpwa_pkg::POS_W'($urandom);
    req.col    = mpwa_pkg::POS_W'($urandom);
    request_queue.push_back(req);
    plane_loaded[addr] = 1'b1;
  endtask

  // Load every in-plane cell of the window that was never written, then pool.
  task automatic queue_pool(input int row, input int col);
    request_t req;
    int       rr;
    int       cc;
    for (int n = 0; n < sat_side(); n++) begin
      for (int m = 0; m < sat_side(); m++) begin
        rr = row * int'(window_stride) + n;
        cc = col * int'(window_stride) + m;
        if (rr < sat_rows() && cc < sat_cols() && !plane_loaded[rr * sat_cols() + cc])
          queue_load(rr * sat_cols() + cc, random_sample());
      end
    end
    req.func   = mpwa_pkg::FUNC_POOL;
    req.addr   = mpwa_pkg::LOAD_W'($urandom);
    req.sample = mpwa_pkg::SAMPLE_W'($urandom);
    req.row    = mpwa_pkg::POS_W'(row);
    req.col    = mpwa_pkg::POS_W'(col);
    request_queue.push_back(req);
  endtask

  // Random part of a phase: mostly pools that land on the plane, plus stray
  // loads anywhere in the store, rewrites inside the plane and far-off pools.
  task automatic run_random(input int steps);
    int pick;
    int reach;
    int row;
    int col;
    repeat (steps) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        queue_load($urandom_range(PLANE_CELLS - 1), random_sample());
      end else if (pick < 25 && sat_rows() * sat_cols() > 0) begin
        queue_load($urandom_range(sat_rows() * sat_cols() - 1), random_sample());
      end else begin
        reach = (window_stride == 0) ? 63 : sat_rows() / int'(window_stride);
        if (reach > 63) reach = 63;
        row = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(reach);
        reach = (window_stride == 0) ? 63 : sat_cols() / int'(window_stride);
        if (reach > 63) reach = 63;
        col = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(reach);
        queue_pool(row, col);
      end
    end
  endtask

  // Write one register and mirror it once the write is taken.
  task automatic write_reg(input logic [mpwa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mpwa_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      mpwa_pkg::REG_IN_HEIGHT:   plane_rows    = data;
      mpwa_pkg::REG_IN_WIDTH:    plane_cols    = data;
      mpwa_pkg::REG_POOL_SIZE:   window_side   = data[mpwa_pkg::WIN_W-1:0];
      mpwa_pkg::REG_STRIDE_STEP: window_stride = data[mpwa_pkg::WIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int height, input int width,
                              input int side, input int stride);
    write_reg(mpwa_pkg::REG_IN_HEIGHT, mpwa_pkg::CFG_DATA_W'(height));
    write_reg(mpwa_pkg::REG_IN_WIDTH, mpwa_pkg::CFG_DATA_W'(width));
    write_reg(mpwa_pkg::REG_POOL_SIZE, mpwa_pkg::CFG_DATA_W'(side));
    write_reg(mpwa_pkg::REG_STRIDE_STEP, mpwa_pkg::CFG_DATA_W'(stride));
  endtask

  // Wait until every request is taken and every result is back, then give
  // the block some quiet cycles. Sample between edges, so that the driver's
  // updates of this edge are already visible.
  task automatic settle();
    do begin
      @(negedge clk);
    end while (request_queue.size() != 0 || in_valid || expected_maxima.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Request driver: apply the request taken at this edge to the bench copy,
  // then offer the next pending request unless this cycle idles.
  always @(posedge clk) begin : drive_requests
    request_t next_req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        requests_taken <= requests_taken + 1;
        if (in_func == mpwa_pkg::FUNC_LOAD)
          plane_copy[in_load_address] = in_sample_value;
        else
          expected_maxima.push_back(window_max(in_out_row, in_out_col));
      end
      if (!in_valid || in_ready) begin
        // No idling for a stretch of requests, so back-to-back traffic is seen too.
        if (request_queue.size() != 0 &&
            ((requests_taken >= 600 && requests_taken < 1000) ||
             $urandom_range(99) >= 11)) begin
          next_req = request_queue.pop_front();
          in_valid        <= 1'b1;
          in_func         <= next_req.func;
          in_load_address <= next_req.addr;
          in_sample_value <= next_req.sample;
          in_out_row      <= next_req.row;
          in_out_col      <= next_req.col;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each taken result against the oldest expectation,
  // then pick out_ready for the next cycle.
  always @(posedge clk) begin : check_results
    pool_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_maxima.size() == 0) begin
          $error("result with no pool request pending: max_value %0d max_index %0d",
                 out_max_value, out_max_index);
          mismatches++;
        end else begin
          want = expected_maxima.pop_front();
          if (out_max_value !== want.value) begin
            $error("max_value: expected %0d, got %0d", want.value, out_max_value);
            mismatches++;
          end
          if (out_max_index !== want.index) begin
            $error("max_index: expected %0d, got %0d", want.index, out_max_index);
            mismatches++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!held_off && results_seen == HOLD_AT) begin
        // Hold off once while the driver keeps offering requests.
        held_off  <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (results_seen >= 300 && results_seen < 600) ||
                     $urandom_range(99) >= 11;
      end
    end
  end

  // Watchdog: end the run if nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset geometry (64 x 64, 2 x 2 window, stride 2).
    // Window holding only the minimum: no maximum, index none.
    queue_load(0, mpwa_pkg::Q_MIN);
    queue_load(1, mpwa_pkg::Q_MIN);
    queue_load(64, mpwa_pkg::Q_MIN);
    queue_load(65, mpwa_pkg::Q_MIN);
    queue_pool(0, 0);
    // Equal samples: the first one in scan order keeps the index.
    queue_load(2, 16'sd5);
    queue_load(3, 16'sd5);
    queue_load(66, 16'sd5);
    queue_load(67, 16'sd5);
    queue_pool(0, 1);
    // Largest sample in the far corner of the plane.
    queue_load(4095, 16'sh7fff);
    queue_load(4094, 16'sh7fff);
    queue_pool(31, 31);
    // Alternating bit patterns on the sample field.
    queue_load(4032, 16'sh5555);
    queue_load(4033, 16'shaaaa);
    // Windows wholly outside the plane.
    queue_pool(63, 63);
    queue_pool(32, 0);
    queue_pool(0, 63);
    settle();

    foreach (phase_plan[p]) begin
      set_geometry(phase_plan[p][0], phase_plan[p][1], phase_plan[p][2], phase_plan[p][3]);
      run_random(phase_plan[p][4]);
      settle();
    end

    repeat (5) begin
      set_geometry($urandom_range(1, 20), $urandom_range(1, 20),
                   $urandom_range(1, WINDOW_MAX), $urandom_range(1, 8));
      run_random(50);
      settle();
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
